FILE: rtl/core/idbe_pkg.sv
package idbe_pkg;

  // fixed field widths of the ports
  localparam int WORD_W  = 32;
  localparam int POS_W   = 8;
  localparam int CODE_W  = 10;
  localparam int LEN_W   = 4;
  localparam int OFFS_W  = 16;
  localparam int BYTES_W = 14;

  // code lengths in bits
  localparam logic [LEN_W-1:0] CHANGE_LEN = 4'd10;
  localparam logic [LEN_W-1:0] END_LEN    = 4'd1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one classified frame waiting for the back part
  typedef struct packed {
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] diff;
    logic              start;
    logic              last;
  } entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

FILE: rtl/core/idbe_front.sv
module idbe_front #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [idbe_pkg::WORD_W-1:0] frame_inputs,
  input  logic                        start_of_message,
  input  logic [idbe_pkg::WORD_W-1:0] reference_inputs,
  input  logic                        end_of_message,
  input  idbe_pkg::queue_status_t     q_status,
  output logic                        q_push,
  output idbe_pkg::entry_t            q_entry
);

  localparam logic [idbe_pkg::WORD_W:0] MASK_EXT =
    ((idbe_pkg::WORD_W+1)'(1) << WORD_BITS) - (idbe_pkg::WORD_W+1)'(1);
  localparam logic [idbe_pkg::WORD_W-1:0] WORD_MASK = MASK_EXT[idbe_pkg::WORD_W-1:0];

  logic [idbe_pkg::WORD_W-1:0] previous_word;
  logic [idbe_pkg::WORD_W-1:0] cur;
  logic [idbe_pkg::WORD_W-1:0] base;

  // accept while the queue has room
  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  // pick the base word and mark changed bits
  always_comb begin
    cur  = frame_inputs & WORD_MASK;
    base = start_of_message ? (reference_inputs & WORD_MASK) : previous_word;
    q_entry.cur   = cur;
    q_entry.diff  = cur ^ base;
    q_entry.start = start_of_message;
    q_entry.last  = end_of_message;
  end

  // last accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_word <= '0;
    end else if (q_push) begin
      previous_word <= cur;
    end
  end

endmodule

FILE: rtl/core/idbe_queue.sv
module idbe_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  idbe_pkg::entry_t        push_entry,
  input  logic                    pop,
  output idbe_pkg::entry_t        head,
  output idbe_pkg::queue_status_t status
);

  localparam int PTR_W = $clog2(idbe_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(idbe_pkg::QUEUE_DEPTH + 1);

  idbe_pkg::entry_t slots [idbe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(idbe_pkg::QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(idbe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(idbe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/idbe_back.sv
module idbe_back #(
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  idbe_pkg::queue_status_t      q_status,
  input  idbe_pkg::entry_t             q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [idbe_pkg::CODE_W-1:0]  code_value,
  output logic [idbe_pkg::LEN_W-1:0]   code_length,
  output logic [idbe_pkg::OFFS_W-1:0]  bit_offset,
  output logic                         frame_done,
  output logic [idbe_pkg::OFFS_W-1:0]  message_bits,
  output logic [idbe_pkg::BYTES_W-1:0] message_bytes
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_END  = 3'b100
  } state_t;

  state_t                        state, state_next;
  logic [CNT_W-1:0]              pos, pos_next;
  logic [idbe_pkg::WORD_W-1:0]   cur_sh, cur_sh_next;
  logic [idbe_pkg::WORD_W-1:0]   diff_sh, diff_sh_next;
  logic                          last_flag, last_flag_next;
  logic [idbe_pkg::OFFS_W-1:0]   bit_counter, bit_counter_next;

  logic                          out_valid_next;
  logic [idbe_pkg::CODE_W-1:0]   code_value_next;
  logic [idbe_pkg::LEN_W-1:0]    code_length_next;
  logic [idbe_pkg::OFFS_W-1:0]   bit_offset_next;
  logic                          frame_done_next;
  logic [idbe_pkg::OFFS_W-1:0]   message_bits_next;
  logic [idbe_pkg::BYTES_W-1:0]  message_bytes_next;

  logic                          out_free;
  logic                          load;
  logic [idbe_pkg::OFFS_W-1:0]   end_total;
  logic [idbe_pkg::OFFS_W:0]     bytes_sum;

  assign out_free  = !out_valid || !out_stall;
  assign end_total = bit_counter + idbe_pkg::OFFS_W'(idbe_pkg::END_LEN);
  assign bytes_sum = {1'b0, end_total} + (idbe_pkg::OFFS_W+1)'(7);

  // sequencer: one bit position per cycle unless a changed bit meets a stalled output, then the end marker
  always_comb begin
    state_next         = state;
    pos_next           = pos;
    cur_sh_next        = cur_sh;
    diff_sh_next       = diff_sh;
    last_flag_next     = last_flag;
    bit_counter_next   = bit_counter;
    out_valid_next     = out_valid && out_stall;
    code_value_next    = code_value;
    code_length_next   = code_length;
    bit_offset_next    = bit_offset;
    frame_done_next    = frame_done;
    message_bits_next  = message_bits;
    message_bytes_next = message_bytes;
    load               = 1'b0;

    unique case (state)
      S_IDLE: begin
        load = !q_status.empty;
      end
      S_SCAN: begin
        if (!diff_sh[0] || out_free) begin
          if (diff_sh[0]) begin
            out_valid_next     = 1'b1;
            code_value_next    = {{(idbe_pkg::POS_W-CNT_W){1'b0}}, pos, cur_sh[0], 1'b1};
            code_length_next   = idbe_pkg::CHANGE_LEN;
            bit_offset_next    = bit_counter;
            frame_done_next    = 1'b0;
            message_bits_next  = '0;
            message_bytes_next = '0;
            bit_counter_next   = bit_counter + idbe_pkg::OFFS_W'(idbe_pkg::CHANGE_LEN);
          end
          cur_sh_next  = cur_sh >> 1;
          diff_sh_next = diff_sh >> 1;
          pos_next     = pos + 1'b1;
          if (pos == CNT_W'(WORD_BITS - 1)) begin
            state_next = S_END;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          code_value_next    = '0;
          code_length_next   = idbe_pkg::END_LEN;
          bit_offset_next    = bit_counter;
          frame_done_next    = 1'b1;
          message_bits_next  = last_flag ? end_total : '0;
          message_bytes_next = last_flag ? bytes_sum[idbe_pkg::OFFS_W:3] : '0;
          bit_counter_next   = end_total;
          load               = !q_status.empty;
          if (q_status.empty) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // take the next frame from the queue
    if (load) begin
      state_next     = S_SCAN;
      pos_next       = '0;
      cur_sh_next    = q_head.cur;
      diff_sh_next   = q_head.diff;
      last_flag_next = q_head.last;
      if (q_head.start) begin
        bit_counter_next = '0;
      end
    end
  end

  assign q_pop = load;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      bit_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      pos         <= pos_next;
      bit_counter <= bit_counter_next;
      out_valid   <= out_valid_next;
    end
  end

  // work and output payload registers
  always_ff @(posedge clk) begin
    cur_sh        <= cur_sh_next;
    diff_sh       <= diff_sh_next;
    last_flag     <= last_flag_next;
    code_value    <= code_value_next;
    code_length   <= code_length_next;
    bit_offset    <= bit_offset_next;
    frame_done    <= frame_done_next;
    message_bits  <= message_bits_next;
    message_bytes <= message_bytes_next;
  end

endmodule

FILE: rtl/core/input_delta_bit_encoder.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | frame_inputs, start_of_message,
//         |           |                     | reference_inputs, end_of_message
// out     | output    | out_valid/out_stall | code_value, code_length, bit_offset,
//         |           |                     | frame_done, message_bits, message_bytes
//
// the back part scans an item one bit position per cycle, unless a changed bit meets a
// stalled output, and then emits the end code
// the scan sequencer sets the rate; a two-entry queue lets the front take items meanwhile
// a stalled output holds the scan at the next changed bit; unchanged bits still advance
// synchronous reset clears the previous word, the bit counter, the queue and out_valid
module input_delta_bit_encoder #(
  parameter int INPUT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [idbe_pkg::WORD_W-1:0]  frame_inputs,
  input  logic                         start_of_message,
  input  logic [idbe_pkg::WORD_W-1:0]  reference_inputs,
  input  logic                         end_of_message,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [idbe_pkg::CODE_W-1:0]  code_value,
  output logic [idbe_pkg::LEN_W-1:0]   code_length,
  output logic [idbe_pkg::OFFS_W-1:0]  bit_offset,
  output logic                         frame_done,
  output logic [idbe_pkg::OFFS_W-1:0]  message_bits,
  output logic [idbe_pkg::BYTES_W-1:0] message_bytes
);

  // only the low 32 bits of a frame reach the ports
  localparam int WORD_BITS = (INPUT_BITS < idbe_pkg::WORD_W) ? INPUT_BITS : idbe_pkg::WORD_W;

  idbe_pkg::queue_status_t q_status;
  idbe_pkg::entry_t        q_entry;
  idbe_pkg::entry_t        q_head;
  logic                    q_push;
  logic                    q_pop;

  // front: classify against the base word
  idbe_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .frame_inputs     (frame_inputs),
    .start_of_message (start_of_message),
    .reference_inputs (reference_inputs),
    .end_of_message   (end_of_message),
    .q_status         (q_status),
    .q_push           (q_push),
    .q_entry          (q_entry)
  );

  // queue between front and back
  idbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // back: emit codes and track the bit offset
  idbe_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_value    (code_value),
    .code_length   (code_length),
    .bit_offset    (bit_offset),
    .frame_done    (frame_done),
    .message_bits  (message_bits),
    .message_bytes (message_bytes)
  );

endmodule

FILE: rtl/core/idbe_checker.sv
module idbe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [idbe_pkg::CODE_W-1:0]  code_value,
  input logic [idbe_pkg::LEN_W-1:0]   code_length,
  input logic [idbe_pkg::OFFS_W-1:0]  bit_offset,
  input logic                         frame_done,
  input logic [idbe_pkg::OFFS_W-1:0]  message_bits,
  input logic [idbe_pkg::BYTES_W-1:0] message_bytes
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_value) && $stable(bit_offset)
      && $stable(frame_done) && $stable(message_bits))
    else $error("stalled result changed");

  // end code is a single zero bit
  a_end_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> code_length == idbe_pkg::END_LEN && code_value == '0)
    else $error("bad end-of-frame code");

  // change code is ten bits with the marker bit set
  a_change_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> code_length == idbe_pkg::CHANGE_LEN && code_value[0])
    else $error("bad change code");

  // totals appear only on end codes
  a_totals: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> message_bits == '0 && message_bytes == '0)
    else $error("totals on a change code");

  // byte count is bits rounded up
  a_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |->
      {2'b00, message_bytes, 3'b000} >= {3'b000, message_bits}
      && {2'b00, message_bytes, 3'b000} < {3'b000, message_bits} + 19'd8)
    else $error("byte count mismatch");

endmodule

bind input_delta_bit_encoder idbe_checker u_idbe_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .code_value    (code_value),
  .code_length   (code_length),
  .bit_offset    (bit_offset),
  .frame_done    (frame_done),
  .message_bits  (message_bits),
  .message_bytes (message_bytes)
);

FILE: tb/input_delta_bit_encoder_test.sv
`timescale 1ns / 100ps

module input_delta_bit_encoder_test;

  localparam int INPUT_BITS = idbe_pkg::WORD_W;
  localparam logic [idbe_pkg::WORD_W-1:0] WORD_MASK =
    {idbe_pkg::WORD_W{1'b1}} >> (idbe_pkg::WORD_W - INPUT_BITS);
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 2 * (INPUT_BITS + 1) + 10;
  localparam int RANDOM_FRAMES = 40;
  localparam int WRAP_FRAMES = 206;

  // one code as it should leave the block
  typedef struct packed {
    logic [idbe_pkg::CODE_W-1:0]  value;
    logic [idbe_pkg::LEN_W-1:0]   len;
    logic [idbe_pkg::OFFS_W-1:0]  offs;
    logic                         done;
    logic [idbe_pkg::OFFS_W-1:0]  mbits;
    logic [idbe_pkg::BYTES_W-1:0] mbytes;
  } code_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [idbe_pkg::WORD_W-1:0]   frame_inputs = '0;
  logic                          start_of_message = 1'b0;
  logic [idbe_pkg::WORD_W-1:0]   reference_inputs = '0;
  logic                          end_of_message = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [idbe_pkg::CODE_W-1:0]   code_value;
  logic [idbe_pkg::LEN_W-1:0]    code_length;
  logic [idbe_pkg::OFFS_W-1:0]   bit_offset;
  logic                          frame_done;
  logic [idbe_pkg::OFFS_W-1:0]   message_bits;
  logic [idbe_pkg::BYTES_W-1:0]  message_bytes;

  // expected codes, oldest first, and the encoder state behind them
  code_t                       code_q[$];
  logic [idbe_pkg::WORD_W-1:0] prev_word = '0;
  logic [idbe_pkg::OFFS_W-1:0] bit_offs = '0;

  int fail_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit hold_request = 1'b0;
  bit send_gaps = 1'b0;
  bit recv_gaps = 1'b0;

  always #1 clk = ~clk;

  input_delta_bit_encoder #(
    .INPUT_BITS(INPUT_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_inputs(frame_inputs),
    .start_of_message(start_of_message),
    .reference_inputs(reference_inputs),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .code_value(code_value),
    .code_length(code_length),
    .bit_offset(bit_offset),
    .frame_done(frame_done),
    .message_bits(message_bits),
    .message_bytes(message_bytes)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // codes for one frame: changed bits in ascending order, then the end code
  task automatic predict_frame(input logic [idbe_pkg::WORD_W-1:0] word, input logic som,
                               input logic [idbe_pkg::WORD_W-1:0] ref_word,
                               input logic eom);
    logic [idbe_pkg::WORD_W-1:0] cur;
    logic [idbe_pkg::WORD_W-1:0] base_word;
    logic [idbe_pkg::WORD_W-1:0] changed;
    logic [idbe_pkg::OFFS_W:0]   total;
    code_t                       c;
    cur = word & WORD_MASK;
    if (som) begin
      base_word = ref_word & WORD_MASK;
      bit_offs = '0;
    end else begin
      base_word = prev_word;
    end
    changed = cur ^ base_word;
    for (int p = 0; p < INPUT_BITS; p++) begin
      if (changed[p]) begin
        c = '0;
        c.value = {idbe_pkg::POS_W'(p), cur[p], 1'b1};
        c.len = idbe_pkg::CHANGE_LEN;
        c.offs = bit_offs;
        code_q.push_back(c);
        bit_offs += idbe_pkg::OFFS_W'(idbe_pkg::CHANGE_LEN);
      end
    end
    c = '0;
    c.len = idbe_pkg::END_LEN;
    c.offs = bit_offs;
    c.done = 1'b1;
    bit_offs += idbe_pkg::OFFS_W'(idbe_pkg::END_LEN);
    // totals only on the last frame of a message, counter already wrapped
    if (eom) begin
      c.mbits = bit_offs;
      total = {1'b0, bit_offs} + (idbe_pkg::OFFS_W+1)'(7);
      c.mbytes = idbe_pkg::BYTES_W'(total >> 3);
    end
    code_q.push_back(c);
    prev_word = cur;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_code();
    code_t want;
    if (code_q.size() == 0) begin
      fail_count++;
      $display("%0t: code with none expected, expected nothing, actual value %0h length %0d",
               $time, code_value, code_length);
    end else begin
      want = code_q.pop_front();
      check_field("code_value", 32'(want.value), 32'(code_value));
      check_field("code_length", 32'(want.len), 32'(code_length));
      check_field("bit_offset", 32'(want.offs), 32'(bit_offset));
      check_field("frame_done", 32'(want.done), 32'(frame_done));
      check_field("message_bits", 32'(want.mbits), 32'(message_bits));
      check_field("message_bytes", 32'(want.mbytes), 32'(message_bytes));
    end
  endtask

  // both handshakes seen at the rising edge, plus the no-progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_code();
      if (in_valid && !in_stall) begin
        predict_frame(frame_inputs, start_of_message, reference_inputs, end_of_message);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("** input_delta_bit_encoder: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stalls, or one long hold when asked
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && recv_gaps && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // offer one frame and wait until it is taken
  task automatic send_frame(input logic [idbe_pkg::WORD_W-1:0] word, input logic som,
                            input logic [idbe_pkg::WORD_W-1:0] ref_word, input logic eom);
    int gap;
    gap = (send_gaps && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_inputs <= word;
    start_of_message <= som;
    reference_inputs <= ref_word;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pauses until every expected code has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (code_q.size() != 0) @(posedge clk);
  endtask

  // next word of a message: random, repeated, or a few bits flipped
  function automatic logic [idbe_pkg::WORD_W-1:0] next_word(
    input logic [idbe_pkg::WORD_W-1:0] word);
    logic [idbe_pkg::WORD_W-1:0] w;
    int flips;
    w = word;
    case ($urandom_range(0, 3))
      0: w = $urandom();
      1: w = word;
      default: begin
        flips = $urandom_range(1, 3);
        repeat (flips) w[$urandom_range(0, idbe_pkg::WORD_W - 1)] ^= 1'b1;
      end
    endcase
    return w;
  endfunction

  // first frames after reset compare against a zero word
  task automatic test_reset_base();
    send_frame(32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_frame(32'hFFFF_FFFF, 1'b0, 32'h1234_5678, 1'b0);
    send_frame(32'h8000_0001, 1'b0, 32'h0000_0000, 1'b1);
    wait_drained();
  endtask

  // start of message uses the reference word and restarts the offset
  task automatic test_start_reference();
    send_frame(32'h5A5A_A5A5, 1'b1, 32'hA5A5_5A5A, 1'b0);
    send_frame(32'h5A5A_A5A5, 1'b0, 32'h0000_0000, 1'b0);
    send_frame(32'hC3C3_0F0F, 1'b1, 32'hC3C3_0F0F, 1'b1);
    send_frame(32'h0000_0001, 1'b1, 32'h0000_0000, 1'b1);
    send_frame(32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0);
    send_frame(32'h0000_0001, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_frame(32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1);
    wait_drained();
  endtask

  // after an end without a new start the offset keeps counting
  task automatic test_no_start_after_end();
    send_frame(32'h0000_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_frame(32'hFFFF_0000, 1'b0, 32'h0000_0000, 1'b1);
    send_frame(32'hFFFF_0000, 1'b0, 32'h0000_0000, 1'b1);
    send_frame(32'h0F0F_F0F0, 1'b0, 32'h0F0F_F0F0, 1'b0);
    wait_drained();
  endtask

  // long receiver hold while frames keep coming, so the input side stalls
  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_frame((i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, i == 0, 32'hAAAA_5555, i == 7);
    end
    wait_drained();
  endtask

  // every bit toggles each frame until the message offset wraps
  task automatic test_counter_wrap();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    for (int i = 0; i < WRAP_FRAMES; i++) begin
      send_frame((i % 2) ? 32'h0000_0000 : 32'hFFFF_FFFF, i == 0, 32'h0000_0000,
                 i == WRAP_FRAMES - 1);
    end
    wait_drained();
  endtask

  // well-formed messages with random content, some frames with random flags
  task automatic test_random_messages();
    int sent;
    int frames;
    logic [idbe_pkg::WORD_W-1:0] word;
    logic [idbe_pkg::WORD_W-1:0] ref_word;
    sent = 0;
    word = $urandom();
    while (sent < RANDOM_FRAMES) begin
      frames = $urandom_range(1, 12);
      send_gaps = $urandom_range(0, 2) != 0;
      recv_gaps = $urandom_range(0, 2) != 0;
      for (int f = 0; f < frames && sent < RANDOM_FRAMES; f++) begin
        ref_word = $urandom_range(0, 1) ? next_word(word) : $urandom();
        word = next_word(word);
        if ($urandom_range(0, 9) == 0) begin
          send_frame(word, 1'($urandom_range(0, 1)), ref_word, 1'($urandom_range(0, 1)));
        end else begin
          send_frame(word, f == 0, ref_word, f == frames - 1);
        end
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_reset_base();
    test_start_reference();
    test_no_start_after_end();
    test_backpressure();
    test_counter_wrap();
    test_random_messages();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** input_delta_bit_encoder: PASSED **");
    end else begin
      $display("** input_delta_bit_encoder: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/idbe_pkg.sv
rtl/core/idbe_front.sv
rtl/core/idbe_queue.sv
rtl/core/idbe_back.sv
rtl/core/input_delta_bit_encoder.sv
rtl/core/idbe_checker.sv
tb/input_delta_bit_encoder_test.sv
